// ===== rtl/ows_pkg.sv =====
// Shared types, constants and the CRC-8 step for the 1-Wire ROM search block.
package ows_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int CODE_BITS   = 64;
    localparam int CRC_BITS    = 56;
    localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

    localparam logic [7:0] CRC_POLY     = 8'h8C;
    localparam logic [7:0] FAMILY_RESET = 8'h28;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESENCE = 2'd1,
        PH_BITS     = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        K_START    = 2'd0,
        K_PRESENCE = 2'd1,
        K_BIT      = 2'd2,
        K_UNUSED   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_BIT      = 3'd0,
        ST_READY    = 3'd1,
        ST_STORED   = 3'd2,
        ST_OTHER    = 3'd3,
        ST_CRC      = 3'd4,
        ST_CONFLICT = 3'd5,
        ST_NOPRES   = 3'd6,
        ST_IGNORED  = 3'd7
    } t_status;

    typedef struct packed {
        t_kind kind;
        logic  presence;
        logic  id_bit;
        logic  comp_bit;
    } t_item;

    typedef struct packed {
        logic        write_bit;
        t_status     status;
        logic [63:0] rom_code;
        logic [2:0]  device_index;
        logic [3:0]  devices_found;
        logic        search_over;
    } t_result;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic b);
        logic [7:0] sh;
        sh = {1'b0, crc[7:1]};
        return (crc[0] ^ b) ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

// ===== rtl/ows_core.sv =====
// Search state and the combinational decision for one registered request.
module ows_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ows_pkg::t_item   i_item,
    input  logic [7:0]       i_family,
    output ows_pkg::t_result o_result
);

    ows_pkg::t_phase   r_phase, n_phase;
    logic [63:0]       r_code, n_code;
    logic [63:0]       r_prev, n_prev;
    logic [6:0]        r_ld, n_ld;
    logic [6:0]        r_lzp, n_lzp;
    logic [6:0]        r_pos, n_pos;
    logic [7:0]        r_crc, n_crc;
    ows_pkg::t_count   r_found, n_found;

    logic [6:0]        pos_m1;
    logic [5:0]        sh;
    logic              disc;
    logic              conflict;
    logic              dir;
    logic [63:0]       code_set;
    logic [7:0]        crc_upd;
    logic [6:0]        lzp_upd;
    logic              last_bit;
    logic              crc_ok;
    logic              fam_hit;
    ows_pkg::t_count   found_inc;
    ows_pkg::t_count   found_after;
    logic [6:0]        ld_after;
    logic              end_after;
    logic [ows_pkg::CNT_W+3:0] found_ext;
    logic [ows_pkg::CNT_W+3:0] idx_ext;

    always_comb begin
        pos_m1    = r_pos - 7'd1;
        sh        = pos_m1[5:0];
        disc      = !i_item.id_bit && !i_item.comp_bit;
        conflict  = i_item.id_bit && i_item.comp_bit;
        if (disc) begin
            if (r_pos < r_ld) begin
                dir = r_prev[sh];
            end else begin
                dir = (r_pos == r_ld);
            end
        end else begin
            dir = i_item.id_bit;
        end
        code_set  = r_code | ({63'd0, dir} << sh);
        crc_upd   = (r_pos <= 7'(ows_pkg::CRC_BITS)) ? ows_pkg::crc_step(r_crc, dir) : r_crc;
        lzp_upd   = (disc && !dir) ? r_pos : r_lzp;
        last_bit  = (r_pos == 7'(ows_pkg::CODE_BITS));
        crc_ok    = (code_set[63:56] == crc_upd);
        fam_hit   = (code_set[7:0] == i_family);
        found_inc = r_found + ows_pkg::t_count'(1);
        found_after = fam_hit ? found_inc : r_found;
        ld_after  = lzp_upd;
        end_after = (ld_after == 7'd0) ||
                    (found_after >= ows_pkg::t_count'(ows_pkg::MAX_DEVICES));
    end

    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_prev  = r_prev;
        n_ld    = r_ld;
        n_lzp   = r_lzp;
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_found = r_found;
        case (i_item.kind)
            ows_pkg::K_START: begin
                n_prev  = '0;
                n_ld    = '0;
                n_found = '0;
                n_phase = ows_pkg::PH_PRESENCE;
            end
            ows_pkg::K_PRESENCE: begin
                if (r_phase == ows_pkg::PH_PRESENCE) begin
                    if (!i_item.presence) begin
                        n_phase = ows_pkg::PH_IDLE;
                    end else begin
                        n_code  = '0;
                        n_lzp   = '0;
                        n_crc   = '0;
                        n_pos   = 7'd1;
                        n_phase = ows_pkg::PH_BITS;
                    end
                end
            end
            ows_pkg::K_BIT: begin
                if (r_phase == ows_pkg::PH_BITS) begin
                    if (conflict) begin
                        n_phase = ows_pkg::PH_IDLE;
                    end else begin
                        n_code = code_set;
                        n_lzp  = lzp_upd;
                        n_crc  = crc_upd;
                        if (!last_bit) begin
                            n_pos = r_pos + 7'd1;
                        end else begin
                            n_pos = 7'd1;
                            if (!crc_ok) begin
                                n_phase = ows_pkg::PH_IDLE;
                            end else begin
                                n_found = found_after;
                                n_prev  = code_set;
                                n_ld    = ld_after;
                                n_phase = end_after ? ows_pkg::PH_IDLE
                                                    : ows_pkg::PH_PRESENCE;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        found_ext = {4'd0, n_found};
        idx_ext   = {4'd0, r_found};
        o_result = '0;
        o_result.status        = ows_pkg::ST_IGNORED;
        o_result.devices_found = found_ext[3:0];
        case (i_item.kind)
            ows_pkg::K_START: begin
                o_result.status = ows_pkg::ST_READY;
            end
            ows_pkg::K_PRESENCE: begin
                if (r_phase == ows_pkg::PH_PRESENCE) begin
                    if (!i_item.presence) begin
                        o_result.status      = ows_pkg::ST_NOPRES;
                        o_result.search_over = 1'b1;
                    end else begin
                        o_result.status = ows_pkg::ST_READY;
                    end
                end
            end
            ows_pkg::K_BIT: begin
                if (r_phase == ows_pkg::PH_BITS) begin
                    if (conflict) begin
                        o_result.status      = ows_pkg::ST_CONFLICT;
                        o_result.search_over = 1'b1;
                    end else if (!last_bit) begin
                        o_result.write_bit = dir;
                        o_result.status    = ows_pkg::ST_BIT;
                    end else begin
                        o_result.write_bit = dir;
                        o_result.rom_code  = code_set;
                        if (!crc_ok) begin
                            o_result.status      = ows_pkg::ST_CRC;
                            o_result.search_over = 1'b1;
                        end else begin
                            o_result.search_over = end_after;
                            if (fam_hit) begin
                                o_result.status       = ows_pkg::ST_STORED;
                                o_result.device_index = idx_ext[2:0];
                            end else begin
                                o_result.status = ows_pkg::ST_OTHER;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ows_pkg::PH_IDLE;
            r_code  <= '0;
            r_prev  <= '0;
            r_ld    <= '0;
            r_lzp   <= '0;
            r_pos   <= 7'd1;
            r_crc   <= '0;
            r_found <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_prev  <= n_prev;
            r_ld    <= n_ld;
            r_lzp   <= n_lzp;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_found <= n_found;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != 7'd0) && (r_pos <= 7'(ows_pkg::CODE_BITS)))
        else $error("Bit position left its range.");

    a_found_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= ows_pkg::t_count'(ows_pkg::MAX_DEVICES))
        else $error("Device count exceeded its limit.");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.status == ows_pkg::ST_STORED)
        |=> (r_found == $past(r_found) + ows_pkg::t_count'(1)))
        else $error("A stored device was not counted.");

    a_over_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.search_over) |=> (r_phase == ows_pkg::PH_IDLE))
        else $error("Search reported over but did not return to idle.");

endmodule

// ===== rtl/onewire_rom_search.sv =====
// Top level of the 1-Wire ROM search master: request register, core and result register.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+----------------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_kind, i_presence, i_id_bit, i_comp_bit
//  out      | output    | o_out_valid / i_out_ready  | o_write_bit, o_status, o_rom_code,
//           |           |                            | o_device_index, o_devices_found,
//           |           |                            | o_search_over
//  cfg      | input     | i_cfg_we                   | i_cfg_wdata (wanted family)
//
// Every request gives exactly one result; it passes from the request register
// into the result register once the result register is free.
// One request per cycle is sustained while i_out_ready stays high; the core decision sits between the
// request register and the result register.
// Reset is synchronous and active low; it returns the search to idle and the
// wanted family to 0x28.
// A stalled result register holds the request register, which then drops o_in_ready.
module onewire_rom_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_presence,
    input  logic        i_id_bit,
    input  logic        i_comp_bit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_write_bit,
    output logic [2:0]  o_status,
    output logic [63:0] o_rom_code,
    output logic [2:0]  o_device_index,
    output logic [3:0]  o_devices_found,
    output logic        o_search_over,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    logic             r_in_valid;
    ows_pkg::t_item   r_item;
    logic             r_out_valid;
    ows_pkg::t_result r_result;
    logic [7:0]       r_family;
    logic             advance;
    ows_pkg::t_result core_result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{kind: ows_pkg::t_kind'(i_kind), presence: i_presence,
                        id_bit: i_id_bit, comp_bit: i_comp_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= ows_pkg::FAMILY_RESET;
        end else if (i_cfg_we) begin
            r_family <= i_cfg_wdata;
        end
    end

    ows_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_family (r_family),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_bit     = r_result.write_bit;
    assign o_status        = r_result.status;
    assign o_rom_code      = r_result.rom_code;
    assign o_device_index  = r_result.device_index;
    assign o_devices_found = r_result.devices_found;
    assign o_search_over   = r_result.search_over;

endmodule
